>>> rtl/core/rvdec_pkg.sv
// Shared types and constants of the RV32I instruction decoder.
// Used by the channel interfaces, the decode logic and the top level; depends on nothing.
package rvdec_pkg;

    localparam int XLEN        = 32;
    localparam int RegIdxWidth = 5;
    localparam int AluOpWidth  = 4;

    // Major opcodes (instruction bits 6..0).
    localparam logic [6:0] OpcLui    = 7'h37;
    localparam logic [6:0] OpcAuipc  = 7'h17;
    localparam logic [6:0] OpcJal    = 7'h6F;
    localparam logic [6:0] OpcJalr   = 7'h67;
    localparam logic [6:0] OpcBranch = 7'h63;
    localparam logic [6:0] OpcLoad   = 7'h03;
    localparam logic [6:0] OpcStore  = 7'h23;
    localparam logic [6:0] OpcOpImm  = 7'h13;
    localparam logic [6:0] OpcOp     = 7'h33;

    // funct3 codes of the integer ALU group.
    localparam logic [2:0] F3AddSub = 3'd0;
    localparam logic [2:0] F3Sll    = 3'd1;
    localparam logic [2:0] F3Slt    = 3'd2;
    localparam logic [2:0] F3Sltu   = 3'd3;
    localparam logic [2:0] F3Xor    = 3'd4;
    localparam logic [2:0] F3Shr    = 3'd5;
    localparam logic [2:0] F3Or     = 3'd6;
    localparam logic [2:0] F3And    = 3'd7;

    typedef enum logic [AluOpWidth-1:0] {
        ALU_ADD          = 4'd0,
        ALU_SUB          = 4'd1,
        ALU_SLL          = 4'd2,
        ALU_SLT          = 4'd3,
        ALU_SLT_UNSIGNED = 4'd4,
        ALU_XOR          = 4'd5,
        ALU_SRL          = 4'd6,
        ALU_SRA          = 4'd7,
        ALU_OR           = 4'd8,
        ALU_AND          = 4'd9
    } alu_op_t;

    // One decoded instruction.
    typedef struct packed {
        logic                   write_register;
        logic                   read_memory;
        logic                   write_memory;
        logic                   load_to_register;
        logic                   use_immediate;
        logic                   is_branch;
        logic                   is_jump;
        alu_op_t                alu_operation;
        logic [XLEN-1:0]        immediate_value;
        logic [RegIdxWidth-1:0] source_one_index;
        logic [RegIdxWidth-1:0] source_two_index;
        logic [RegIdxWidth-1:0] dest_index;
    } decode_t;

endpackage

>>> rtl/core/rvdec_if.sv
// Valid/ready channel interfaces of the RV32I instruction decoder.
// Depends on rvdec_pkg for field widths.
interface rvdec_instr_if;
    logic                        valid;
    logic                        ready;
    logic [rvdec_pkg::XLEN-1:0]  instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvdec_result_if;
    logic                              valid;
    logic                              ready;
    logic                              write_register;
    logic                              read_memory;
    logic                              write_memory;
    logic                              load_to_register;
    logic                              use_immediate;
    logic                              is_branch;
    logic                              is_jump;
    logic [rvdec_pkg::AluOpWidth-1:0]  alu_operation;
    logic [rvdec_pkg::XLEN-1:0]        immediate_value;
    logic [rvdec_pkg::RegIdxWidth-1:0] source_one_index;
    logic [rvdec_pkg::RegIdxWidth-1:0] source_two_index;
    logic [rvdec_pkg::RegIdxWidth-1:0] dest_index;

    modport source (
        output valid, output write_register, output read_memory, output write_memory,
        output load_to_register, output use_immediate, output is_branch, output is_jump,
        output alu_operation, output immediate_value, output source_one_index,
        output source_two_index, output dest_index, input ready
    );
    modport sink (
        input valid, input write_register, input read_memory, input write_memory,
        input load_to_register, input use_immediate, input is_branch, input is_jump,
        input alu_operation, input immediate_value, input source_one_index,
        input source_two_index, input dest_index, output ready
    );
endinterface

>>> rtl/core/rv32i_instruction_decoder.sv
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
// Depends on rvdec_pkg, the channel interfaces in rvdec_if and rvdec_decode.

// The decoder takes one instruction word per clock cycle while the result side is
// ready and returns one decoded beat per instruction. The word lands in an input
// register, passes through one level of decode logic and is captured in a result
// register; both stages advance in the same cycle, so a new beat is taken while the
// previous result waits. A stall on the result side propagates back to instr.ready
// in the same cycle, and decoding resumes at one beat per cycle as soon as
// result.ready returns.
module rv32i_instruction_decoder (
    input logic          clk,
    input logic          rst_n,
    rvdec_instr_if.sink  instr,
    rvdec_result_if.source result
);
    import rvdec_pkg::*;

    logic            word_valid_reg;
    logic [XLEN-1:0] word_reg;
    logic            res_valid_reg;
    decode_t         res_reg;
    decode_t         dec;
    logic            res_load;
    logic            word_load;

    // Pipeline advance: each stage moves when its downstream stage has room.
    assign res_load  = word_valid_reg && (!res_valid_reg || result.ready);
    assign word_load = instr.valid && instr.ready;
    assign instr.ready = !word_valid_reg || res_load;

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            word_valid_reg <= instr.valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (word_load)
        begin
            word_reg <= instr.instruction_word;
        end
    end

    rvdec_decode u_decode (
        .word (word_reg),
        .dec  (dec)
    );

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || result.ready)
        begin
            res_valid_reg <= word_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= dec;
        end
    end

    // Drive the result channel from the result register.
    assign result.valid            = res_valid_reg;
    assign result.write_register   = res_reg.write_register;
    assign result.read_memory      = res_reg.read_memory;
    assign result.write_memory     = res_reg.write_memory;
    assign result.load_to_register = res_reg.load_to_register;
    assign result.use_immediate    = res_reg.use_immediate;
    assign result.is_branch        = res_reg.is_branch;
    assign result.is_jump          = res_reg.is_jump;
    assign result.alu_operation    = AluOpWidth'(res_reg.alu_operation);
    assign result.immediate_value  = res_reg.immediate_value;
    assign result.source_one_index = res_reg.source_one_index;
    assign result.source_two_index = res_reg.source_two_index;
    assign result.dest_index       = res_reg.dest_index;

endmodule

>>> rtl/core/rvdec_decode.sv
// Combinational decode of one RV32I instruction word into control flags,
// ALU operation, immediate and register indices. Depends on rvdec_pkg.
module rvdec_decode (
    input  logic [rvdec_pkg::XLEN-1:0] word,
    output rvdec_pkg::decode_t         dec
);
    import rvdec_pkg::*;

    logic [6:0]      opcode;
    logic [2:0]      funct3;
    logic            bit30;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_u;
    logic [XLEN-1:0] imm_j;
    alu_op_t         alu_f3;

    assign opcode = word[6:0];
    assign funct3 = word[14:12];
    assign bit30  = word[30];

    // Immediates of all five formats, sign-extended from bit 31.
    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {word[31:12], 12'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

    // ALU operation from funct3; subtract only for the register-register class.
    always_comb
    begin
        unique case (funct3)
            F3AddSub: alu_f3 = (opcode == OpcOp && bit30) ? ALU_SUB : ALU_ADD;
            F3Sll:    alu_f3 = ALU_SLL;
            F3Slt:    alu_f3 = ALU_SLT;
            F3Sltu:   alu_f3 = ALU_SLT_UNSIGNED;
            F3Xor:    alu_f3 = ALU_XOR;
            F3Shr:    alu_f3 = bit30 ? ALU_SRA : ALU_SRL;
            F3Or:     alu_f3 = ALU_OR;
            F3And:    alu_f3 = ALU_AND;
            default:  alu_f3 = ALU_AND;
        endcase
    end

    // Class decode; unknown opcodes leave every flag low, add and a zero immediate.
    always_comb
    begin
        dec                  = '0;
        dec.alu_operation    = ALU_ADD;
        dec.source_one_index = word[19:15];
        dec.source_two_index = word[24:20];
        dec.dest_index       = word[11:7];
        unique case (opcode)
            OpcLui, OpcAuipc:
            begin
                dec.write_register  = 1'b1;
                dec.use_immediate   = 1'b1;
                dec.immediate_value = imm_u;
            end
            OpcJal:
            begin
                dec.write_register  = 1'b1;
                dec.is_jump         = 1'b1;
                dec.immediate_value = imm_j;
            end
            OpcJalr:
            begin
                dec.write_register  = 1'b1;
                dec.is_jump         = 1'b1;
                dec.use_immediate   = 1'b1;
                dec.immediate_value = imm_i;
            end
            OpcBranch:
            begin
                dec.is_branch       = 1'b1;
                dec.immediate_value = imm_b;
            end
            OpcLoad:
            begin
                dec.write_register   = 1'b1;
                dec.read_memory      = 1'b1;
                dec.load_to_register = 1'b1;
                dec.use_immediate    = 1'b1;
                dec.immediate_value  = imm_i;
            end
            OpcStore:
            begin
                dec.write_memory    = 1'b1;
                dec.use_immediate   = 1'b1;
                dec.immediate_value = imm_s;
            end
            OpcOpImm:
            begin
                dec.write_register  = 1'b1;
                dec.use_immediate   = 1'b1;
                dec.immediate_value = imm_i;
                dec.alu_operation   = alu_f3;
            end
            OpcOp:
            begin
                dec.write_register = 1'b1;
                dec.alu_operation  = alu_f3;
            end
            default:
            begin
                dec.alu_operation = ALU_ADD;
            end
        endcase
    end

endmodule

>>> rtl/core/rvdec_checker.sv
// Port-level checks of the RV32I instruction decoder and the bind that attaches them.
// Depends on rvdec_pkg and on the top level rv32i_instruction_decoder.
module rvdec_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic                              write_register,
    input logic                              read_memory,
    input logic                              write_memory,
    input logic                              load_to_register,
    input logic                              use_immediate,
    input logic                              is_branch,
    input logic                              is_jump,
    input logic [rvdec_pkg::AluOpWidth-1:0]  alu_operation,
    input logic [rvdec_pkg::XLEN-1:0]        immediate_value
);
    import rvdec_pkg::*;

    // No result beat may be offered in the cycle right after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result beat offered right after reset");

    // A stalled result beat keeps its decoded content.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(immediate_value) && $stable(alu_operation)
             && $stable(write_register)))
        else $error("stalled result beat changed");

    // A load sets its whole flag group and never writes memory.
    a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && read_memory) |->
            (write_register && load_to_register && use_immediate && !write_memory))
        else $error("inconsistent load flags");

    // Branch and JAL offsets are halfword aligned.
    a_offset_align: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (is_branch || (is_jump && !use_immediate))) |->
            (immediate_value[0] == 1'b0))
        else $error("misaligned branch or jump offset");

    // An instruction with no effect decodes to add with a zero immediate.
    a_unknown_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !write_register && !write_memory && !is_branch) |->
            (alu_operation == AluOpWidth'(ALU_ADD) && immediate_value == '0
             && !use_immediate && !is_jump && !read_memory))
        else $error("unknown opcode produced a nonzero decode");

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .write_register   (result.write_register),
    .read_memory      (result.read_memory),
    .write_memory     (result.write_memory),
    .load_to_register (result.load_to_register),
    .use_immediate    (result.use_immediate),
    .is_branch        (result.is_branch),
    .is_jump          (result.is_jump),
    .alu_operation    (result.alu_operation),
    .immediate_value  (result.immediate_value)
);
